>>> hw/rtl/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared types and constants of the RGB Sobel edge detector.
// ----------------------------------------------------------------------------
package sobel_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int DIM_W     = 11;
    localparam int PIX_W     = 24;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

    // Register indexes on the configuration port.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } sobel_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_last;
    } sobel_out_t;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

endpackage

>>> hw/rtl/sobel_ram.sv
// ----------------------------------------------------------------------------
// sobel_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sobel_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/sobel_edge_rgb.sv
// ----------------------------------------------------------------------------
// sobel_edge_rgb
// Streaming 3x3 Sobel edge detector on RGB pixels with two line RAMs.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order; each result trails its pixel by one row and
// one column, border pixels pass unchanged, and flush requests drain pending
// pixels. One request is handled at a time: a pixel that yields no result
// goes through read and window update only, an interior result through read,
// window update, gradient, square, eight steps of the per-channel square root
// unit and output, a border result skips square and root; a flush is dropped
// when nothing is pending and otherwise reads and outputs the oldest pending
// pixel. A result stays in the output stage while the output register still
// holds an unaccepted result, so receiver hold-off stalls the block. The output
// register lets a request enter while the previous result waits. Writing either register restarts the stream.
module sobel_edge_rgb
    import sobel_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  sobel_in_t   in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output sobel_out_t  out_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_GRAD  = 6'b000100,
        S_SQ    = 6'b001000,
        S_ROOT  = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [DIM_W-1:0]  w_eff, h_eff;
    logic [COL_W-1:0]  col_reg;
    logic [DIM_W-1:0]  row_reg;
    logic [DIM_W-1:0]  pend_reg;
    logic [COL_W-1:0]  ocol_reg;
    logic [DIM_W-1:0]  orow_reg;
    logic [PIX_W-1:0]  win_reg [9];
    sobel_in_t         req_reg;
    logic              sel_old_reg;
    logic [PIX_W-1:0]  res_reg;
    logic signed [10:0] gx_reg [3];
    logic signed [10:0] gy_reg [3];
    logic [15:0]       sq_reg [3];
    logic [2:0]        sat_reg;
    logic [7:0]        root_reg [3];
    logic [2:0]        step_reg;
    logic              out_valid_reg;
    sobel_out_t        out_reg;

    logic              cfg_wr;
    logic              accept;
    logic [11:0]       fl_sum;
    logic [COL_W-1:0]  fl_new_addr, fl_old_addr;
    logic [COL_W-1:0]  new_raddr, old_raddr;
    logic [PIX_W-1:0]  new_rdata, old_rdata;
    logic              ram_we;
    logic              produce;
    logic              interior;
    logic              emit_go;
    logic [7:0]        bit_mask;
    logic [10:0]       gx_pos [3], gx_neg [3], gy_pos [3], gy_neg [3];
    logic [21:0]       sum_sq [3];
    logic [7:0]        trial [3];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[1:0] == 2'b00);
    assign prdata = (paddr[2] == REG_WIDTH) ? {21'd0, width_reg} : {21'd0, height_reg};

    assign w_eff = (width_reg == '0) ? 11'd1 :
                   (width_reg > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg == '0) ? 11'd1 : height_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Flush reads: the oldest pending pixel sits pend_reg places back in the newer
    // row, or one column back in the older row when a full row plus one waits.
    assign fl_sum      = 12'({1'b0, col_reg}) + 12'(w_eff) - 12'(pend_reg);
    assign fl_new_addr = (fl_sum >= 12'(w_eff)) ? COL_W'(fl_sum - 12'(w_eff))
                                                 : COL_W'(fl_sum);
    assign fl_old_addr = (col_reg == '0) ? COL_W'(w_eff - 11'd1) : col_reg - 1'b1;
    assign new_raddr   = (in_data.mode == MODE_FLUSH) ? fl_new_addr : col_reg;
    assign old_raddr   = (in_data.mode == MODE_FLUSH) ? fl_old_addr : col_reg;

    assign ram_we  = (state_reg == S_FETCH) && (req_reg.mode == MODE_PIXEL);
    assign produce = (pend_reg > w_eff);

    sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_new_row (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata ({req_reg.in_red, req_reg.in_green, req_reg.in_blue}),
        .raddr (new_raddr),
        .rdata (new_rdata)
    );

    sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_old_row (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (new_rdata),
        .raddr (old_raddr),
        .rdata (old_rdata)
    );

    assign interior = (orow_reg >= 11'd1) && (12'(orow_reg) + 12'd2 <= 12'(h_eff)) &&
                      (ocol_reg >= 1'b1) && (12'(ocol_reg) + 12'd2 <= 12'(w_eff));

    assign bit_mask = 8'd1 << step_reg;
    assign emit_go  = !out_valid_reg || out_ready;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            gx_pos[ch] = 11'(win_reg[2][8*ch +: 8]) + {2'b0, win_reg[5][8*ch +: 8], 1'b0}
                       + 11'(win_reg[8][8*ch +: 8]);
            gx_neg[ch] = 11'(win_reg[0][8*ch +: 8]) + {2'b0, win_reg[3][8*ch +: 8], 1'b0}
                       + 11'(win_reg[6][8*ch +: 8]);
            gy_pos[ch] = 11'(win_reg[6][8*ch +: 8]) + {2'b0, win_reg[7][8*ch +: 8], 1'b0}
                       + 11'(win_reg[8][8*ch +: 8]);
            gy_neg[ch] = 11'(win_reg[0][8*ch +: 8]) + {2'b0, win_reg[1][8*ch +: 8], 1'b0}
                       + 11'(win_reg[2][8*ch +: 8]);
            sum_sq[ch] = 22'(gx_reg[ch] * gx_reg[ch]) + 22'(gy_reg[ch] * gy_reg[ch]);
            trial[ch]  = root_reg[ch] | bit_mask;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !(in_data.mode == MODE_FLUSH && pend_reg == '0))
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                if (req_reg.mode == MODE_FLUSH)
                begin
                    state_next = S_EMIT;
                end
                else if (produce)
                begin
                    state_next = S_GRAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_GRAD:
            begin
                state_next = interior ? S_SQ : S_EMIT;
            end
            S_SQ:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (step_reg == '0)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            pend_reg      <= '0;
            ocol_reg      <= '0;
            orow_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EMIT && emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wr)
            begin
                if (paddr[2] == REG_WIDTH)
                begin
                    width_reg <= pwdata[DIM_W-1:0];
                end
                else
                begin
                    height_reg <= pwdata[DIM_W-1:0];
                end
                col_reg  <= '0;
                row_reg  <= '0;
                pend_reg <= '0;
                ocol_reg <= '0;
                orow_reg <= '0;
                for (int i = 0; i < 9; i++)
                begin
                    win_reg[i] <= '0;
                end
            end

            if (accept && in_data.mode == MODE_FLUSH && pend_reg != '0)
            begin
                pend_reg <= pend_reg - 1'b1;
            end

            if (state_reg == S_FETCH && req_reg.mode == MODE_PIXEL)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[3*k]   <= win_reg[3*k+1];
                    win_reg[3*k+1] <= win_reg[3*k+2];
                end
                win_reg[2] <= old_rdata;
                win_reg[5] <= new_rdata;
                win_reg[8] <= {req_reg.in_red, req_reg.in_green, req_reg.in_blue};
                if (!produce)
                begin
                    pend_reg <= pend_reg + 1'b1;
                end
                if (11'(col_reg) + 11'd1 >= w_eff)
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg + 11'd1 >= h_eff) ? '0 : row_reg + 11'd1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end

            if (state_reg == S_EMIT && emit_go)
            begin
                if (11'(ocol_reg) + 11'd1 >= w_eff)
                begin
                    ocol_reg <= '0;
                    orow_reg <= (orow_reg + 11'd1 >= h_eff) ? '0 : orow_reg + 11'd1;
                end
                else
                begin
                    ocol_reg <= ocol_reg + 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg     <= in_data;
            sel_old_reg <= (pend_reg > w_eff);
        end

        if (state_reg == S_FETCH && req_reg.mode == MODE_FLUSH)
        begin
            res_reg <= sel_old_reg ? old_rdata : new_rdata;
        end

        if (state_reg == S_GRAD)
        begin
            res_reg <= win_reg[4];
            for (int ch = 0; ch < 3; ch++)
            begin
                gx_reg[ch] <= $signed(gx_pos[ch] - gx_neg[ch]);
                gy_reg[ch] <= $signed(gy_pos[ch] - gy_neg[ch]);
            end
        end

        if (state_reg == S_SQ)
        begin
            step_reg <= 3'd7;
            for (int ch = 0; ch < 3; ch++)
            begin
                sq_reg[ch]   <= sum_sq[ch][15:0];
                sat_reg[ch]  <= (sum_sq[ch][21:16] != '0);
                root_reg[ch] <= '0;
            end
        end

        // One result bit per channel and cycle, most significant first.
        if (state_reg == S_ROOT)
        begin
            step_reg <= step_reg - 1'b1;
            for (int ch = 0; ch < 3; ch++)
            begin
                if (16'(trial[ch] * trial[ch]) <= sq_reg[ch])
                begin
                    root_reg[ch] <= trial[ch];
                end
            end
            if (step_reg == '0)
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    if (sat_reg[ch])
                    begin
                        res_reg[8*ch +: 8] <= 8'hFF;
                    end
                    else if (16'(trial[ch] * trial[ch]) <= sq_reg[ch])
                    begin
                        res_reg[8*ch +: 8] <= trial[ch];
                    end
                    else
                    begin
                        res_reg[8*ch +: 8] <= root_reg[ch];
                    end
                end
            end
        end

        if (state_reg == S_EMIT && emit_go)
        begin
            out_reg.out_red    <= res_reg[23:16];
            out_reg.out_green  <= res_reg[15:8];
            out_reg.out_blue   <= res_reg[7:0];
            out_reg.frame_last <= (orow_reg == h_eff - 11'd1) &&
                                  (11'(ocol_reg) == w_eff - 11'd1);
        end
    end

endmodule

>>> bench/sobel_edge_rgb_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sobel_edge_rgb_tb
// Self-checking bench for the streaming RGB Sobel edge detector. A short
// table of directed requests runs first, then randomized frames under many
// frame sizes. Every accepted request goes through a behavioral model of the
// line stores and window, and every result is checked in order against it or the table value.
// ----------------------------------------------------------------------------
module sobel_edge_rgb_tb;
    import sobel_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 40;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    sobel_in_t   in_data;
    logic        out_valid;
    logic        out_ready;
    sobel_out_t  out_data;

    sobel_edge_rgb i_dut (.*);

    // Behavioral state of the detector.
    logic [PIX_W-1:0] newer_row [MAX_WIDTH];
    logic [PIX_W-1:0] older_row [MAX_WIDTH];
    logic [PIX_W-1:0] window [9];
    int unsigned      row_pos;
    int unsigned      col_pos;
    int unsigned      pending;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    sobel_out_t expected_pixels[$];
    sobel_out_t exp_px;
    int         mismatches;
    bit         quiet;
    bit         hold_request;
    int         hold_left;
    int         idle_cycles;

    typedef struct {
        bit          setup;
        int          cfg_w;
        int          cfg_h;
        sobel_in_t   req;
        bit          typed;
        sobel_out_t  want;
    } vector_t;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function automatic logic [7:0] magnitude(int unsigned s);
        logic [7:0] r;
        logic [7:0] t;
        r = 0;
        if (s >= 65536) return 8'hff;
        for (int b = 7; b >= 0; b--)
        begin
            t = r | (8'd1 << b);
            if (t * t <= s) r = t;
        end
        return r;
    endfunction

    function automatic void clear_stream();
        row_pos = 0;
        col_pos = 0;
        pending = 0;
        for (int k = 0; k < 9; k++) window[k] = '0;
    endfunction

    function automatic sobel_out_t make_result(logic [23:0] px, int unsigned q,
                                               int unsigned w, int unsigned h);
        sobel_out_t r;
        r.out_red    = px[23:16];
        r.out_green  = px[15:8];
        r.out_blue   = px[7:0];
        r.frame_last = (q / w == h - 1) && (q % w == w - 1);
        return r;
    endfunction

    // Advances the model by one accepted request; returns 1 with a result.
    function automatic bit edge_predict(sobel_in_t req, output sobel_out_t res);
        int unsigned w, h, total, c, p, q, orow, ocol;
        logic [23:0] px, top, mid, acc;
        int gx, gy, v;
        w = eff_width();
        h = eff_height();
        total = w * h;
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        p = row_pos * w + c;
        if (req.mode == MODE_FLUSH)
        begin
            if (pending == 0) return 0;
            if (pending <= w) px = newer_row[(c + w - pending) % w];
            else px = older_row[(c + w - 1) % w];
            q = (p + 2 * total - pending) % total;
            res = make_result(px, q, w, h);
            pending--;
            return 1;
        end
        px = {req.in_red, req.in_green, req.in_blue};
        top = older_row[c];
        mid = newer_row[c];
        for (int k = 0; k < 3; k++)
        begin
            window[3*k] = window[3*k+1];
            window[3*k+1] = window[3*k+2];
        end
        window[2] = top;
        window[5] = mid;
        window[8] = px;
        older_row[c] = mid;
        newer_row[c] = px;
        pending++;
        edge_predict = 0;
        if (pending > w + 1)
        begin
            pending--;
            q = (p + 2 * total - (w + 1)) % total;
            orow = q / w;
            ocol = q % w;
            acc = window[4];
            if (orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w)
            begin
                for (int sh = 0; sh <= 16; sh += 8)
                begin
                    gx = 0;
                    gy = 0;
                    for (int i = 0; i < 9; i++)
                    begin
                        v = (window[i] >> sh) & 255;
                        gx += v * ((i % 3) - 1) * ((i == 3 || i == 5) ? 2 : 1);
                        gy += v * ((i / 3) - 1) * ((i == 1 || i == 7) ? 2 : 1);
                    end
                    acc[sh +: 8] = magnitude(gx * gx + gy * gy);
                end
            end
            res = make_result(acc, q, w, h);
            edge_predict = 1;
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
        col_pos = c;
    endfunction

    function automatic void report_bad(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endfunction

    task automatic apb_access(logic is_write, logic idx, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes both frame registers, reads them back, restarts the model.
    task automatic set_frame(int w, int h);
        logic [31:0] rd;
        apb_access(1'b1, REG_WIDTH, 32'(w), rd);
        apb_access(1'b1, REG_HEIGHT, 32'(h), rd);
        width_reg = DIM_W'(w);
        height_reg = DIM_W'(h);
        clear_stream();
        apb_access(1'b0, REG_WIDTH, 32'd0, rd);
        if (rd !== {21'd0, width_reg}) report_bad("width readback", 32'(width_reg), rd);
        apb_access(1'b0, REG_HEIGHT, 32'd0, rd);
        if (rd !== {21'd0, height_reg}) report_bad("height readback", 32'(height_reg), rd);
    endtask

    // Waits until every pending result is out and the block has gone quiet.
    task automatic settle();
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // in_ready only moves at rising edges, so its value at the falling edge
    // tells whether the request is taken at the next rising edge.
    task automatic send_request(sobel_in_t req, bit typed, sobel_out_t want);
        sobel_out_t res;
        if (!quiet && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        if (edge_predict(req, res)) expected_pixels.push_back(typed ? want : res);
    endtask

    function automatic sobel_in_t pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        return '{mode: MODE_PIXEL, in_red: r, in_green: g, in_blue: b};
    endfunction

    function automatic sobel_in_t random_request(int flush_pct);
        sobel_in_t req;
        req = pixel(8'($urandom), 8'($urandom), 8'($urandom));
        if ($urandom_range(9) == 0) req.in_red = $urandom_range(1) ? 8'hff : 8'h00;
        if ($urandom_range(9) == 0) req.in_green = $urandom_range(1) ? 8'hff : 8'h00;
        if ($urandom_range(9) == 0) req.in_blue = $urandom_range(1) ? 8'hff : 8'h00;
        if ($urandom_range(99) < flush_pct) req.mode = MODE_FLUSH;
        return req;
    endfunction

    // Receiver: random back-pressure, one long hold-off, and result checking.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                    report_bad("unexpected result", 32'd0, 32'(out_data));
                else
                begin
                    exp_px = expected_pixels.pop_front();
                    if (exp_px !== out_data)
                        report_bad("result", 32'(exp_px), 32'(out_data));
                end
            end
            if (hold_request && hold_left == 0)
            begin
                hold_left <= 400;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= (hold_left == 1);
            end
            else
                out_ready <= quiet || ($urandom_range(99) >= 22);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    vector_t table_rows[$];

    function automatic void add_row(sobel_in_t req, bit typed = 0,
                                    sobel_out_t want = '0);
        table_rows.push_back('{setup: 0, cfg_w: 0, cfg_h: 0, req: req,
                               typed: typed, want: want});
    endfunction

    function automatic void add_setup(int w, int h);
        table_rows.push_back('{setup: 1, cfg_w: w, cfg_h: h, req: '0,
                               typed: 0, want: '0});
    endfunction

    function automatic sobel_in_t flush_req();
        return '{mode: MODE_FLUSH, in_red: 8'h5a, in_green: 8'ha5, in_blue: 8'h3c};
    endfunction

    initial
    begin
        int w, h, count, flush_pct;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        quiet = 0;
        hold_request = 0;
        mismatches = 0;
        idle_cycles = 0;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            newer_row[i] = '0;
            older_row[i] = '0;
        end
        clear_stream();

        // Reset size: flushes hand back the pending pixels untouched.
        add_row(flush_req());
        add_row(pixel(8'hff, 8'hff, 8'hff));
        add_row(pixel(8'h00, 8'h00, 8'h00));
        add_row(flush_req(), 1, '{8'hff, 8'hff, 8'hff, 1'b0});
        add_row(flush_req(), 1, '{8'h00, 8'h00, 8'h00, 1'b0});
        add_row(flush_req());
        // One-pixel frames: every result is a border pixel and ends a frame.
        add_setup(1, 1);
        add_row(pixel(8'hff, 8'h00, 8'hff));
        add_row(pixel(8'h00, 8'hff, 8'h00));
        add_row(pixel(8'h12, 8'h34, 8'h56), 1, '{8'hff, 8'h00, 8'hff, 1'b1});
        add_row(flush_req(), 1, '{8'h00, 8'hff, 8'h00, 1'b1});
        add_row(flush_req(), 1, '{8'h12, 8'h34, 8'h56, 1'b1});
        add_row(flush_req());
        // A 3x3 frame with a saturating interior pixel, then a full drain.
        add_setup(3, 3);
        for (int i = 0; i < 9; i++)
            add_row(i % 3 == 2 ? pixel(8'hff, 8'h80, 8'hff) : pixel(8'h00, 8'h00, 8'h01));
        for (int i = 0; i < 4; i++) add_row(flush_req());

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
        begin
            if (table_rows[i].setup)
            begin
                in_valid <= 1'b0;
                settle();
                set_frame(table_rows[i].cfg_w, table_rows[i].cfg_h);
            end
            else
                send_request(table_rows[i].req, table_rows[i].typed, table_rows[i].want);
        end

        for (int ph = 0; ph < 14; ph++)
        begin
            in_valid <= 1'b0;
            settle();
            quiet = (ph == 4);
            count = 75;
            flush_pct = 12;
            if ($urandom_range(9) < 7) w = $urandom_range(1, 8);
            else
            begin
                case ($urandom_range(3))
                    0: w = 0;
                    1: w = 3;
                    2: w = 2047;
                    default: w = $urandom_range(9, 40);
                endcase
            end
            h = ($urandom_range(7) == 0) ? 2047 : $urandom_range(0, 7);
            if (ph == 2)
            begin
                // Small frame so that results pile up behind the hold-off.
                w = 5;
                h = 6;
            end
            if (ph == 6)
            begin
                // The widest line: every pixel stays a border pixel.
                w = 1024;
                h = 0;
                count = 60;
                flush_pct = 1;
            end
            if (ph == 13)
            begin
                w = 1;
                h = 2047;
            end
            set_frame(w, h);
            if (ph == 2) hold_request <= 1'b1;
            for (int n = 0; n < count; n++)
            begin
                send_request(random_request(flush_pct), 0, '0);
                if (ph == 2 && n == 3) hold_request <= 1'b0;
            end
            if ($urandom_range(1))
                for (int n = 0; n < pending + 2; n++) send_request(flush_req(), 0, '0);
        end
        in_valid <= 1'b0;
        settle();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
